// ===== src/wssh_pkg.sv =====
// Package for the weather station serial host: beat types, codes and constants.
// No dependencies; every module of the block imports it.
package wssh_pkg;

  localparam int MAX_NIBBLES = 80;
  localparam int IDX_W = $clog2(MAX_NIBBLES);
  localparam int CNT_W = $clog2(MAX_NIBBLES + 1);
  localparam int LEN_W = 7;

  localparam logic [7:0] SET_CODE_RST   = 8'd18;
  localparam logic [7:0] UNSET_CODE_RST = 8'd50;
  localparam logic [7:0] WR_CODE_RST    = 8'd66;

  localparam logic [7:0] ADDR_TX_BASE = 8'h82;
  localparam logic [7:0] RD_TX_BASE   = 8'hC2;
  localparam logic [7:0] RD_ACK_BASE  = 8'h30;
  localparam logic [7:0] RESET_TX     = 8'h06;
  localparam logic [7:0] RESET_REPLY  = 8'h02;
  localparam logic [7:0] ACK_K_SET    = 8'h04;
  localparam logic [7:0] ACK_K_UNSET  = 8'h0C;
  localparam logic [7:0] ACK_K_NIB    = 8'h10;

  typedef enum logic [1:0] {
    CFG_SET_CODE   = 2'd0,
    CFG_UNSET_CODE = 2'd1,
    CFG_WR_CODE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_RESET   = 3'd1,
    OP_READ    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_RX      = 3'd4,
    OP_TIMEOUT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_UNSET = 2'd1,
    MODE_NIB   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ACK  = 3'd1,
    ST_BAD_SUM  = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_BAD_ARG  = 3'd4,
    ST_NO_REPLY = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RESET   = 4'd1,
    PH_ADDR_RD = 4'd2,
    PH_ADDR_WR = 4'd3,
    PH_RD_CMD  = 4'd4,
    PH_RD_DATA = 4'd5,
    PH_RD_SUM  = 4'd6,
    PH_WR_DATA = 4'd7
  } phase_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [15:0]      address;
    logic [LEN_W-1:0] count;
    logic [1:0]       mode;
    logic [3:0]       nibble;
    logic [7:0]       rx_byte;
  } wssh_in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [2:0] status;
  } wssh_out_t;

  typedef struct packed {
    logic [7:0] set_code;
    logic [7:0] unset_code;
    logic [7:0] wr_code;
  } wssh_cfg_t;

endpackage

// ===== src/wssh_nib_buf.sv =====
// Write nibble buffer: one write port, one read port with registered data.
// Depends on wssh_pkg for depth and index width.
module wssh_nib_buf import wssh_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [3:0]       wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [3:0]       rdata_o
);

  logic [3:0] mem [MAX_NIBBLES];
  logic [3:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/wssh_engine.sv =====
// Protocol engine: transaction state and the step rule for one event beat.
// Depends on wssh_pkg and wssh_nib_buf.
module wssh_engine import wssh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  wssh_in_t  item_i,
  input  wssh_cfg_t cfg_i,
  output logic      res_valid_o,
  output wssh_out_t res_o
);

  phase_e           phase_q, phase_d;
  logic [15:0]      addr_q, addr_d;
  logic [LEN_W-1:0] step_q, step_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [1:0]       mode_q, mode_d;
  logic [7:0]       exp_ack_q, exp_ack_d;
  logic [7:0]       sum_q, sum_d;
  logic             seen_q, seen_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d;

  logic             buf_we;
  logic [IDX_W-1:0] buf_raddr;
  logic [3:0]       buf_rdata;

  logic [LEN_W-1:0] step_inc;
  logic [LEN_W-1:0] nbyte;
  logic [LEN_W:0]   len_plus;
  logic [3:0]       start_nib;
  logic [3:0]       next_nib;
  logic [7:0]       wr_code;
  logic [7:0]       wr_k;
  logic [LEN_W-1:0] prefetch;

  function automatic logic [3:0] addr_nib(logic [15:0] a, logic [1:0] idx);
    logic [3:0] n;
    unique case (idx)
      2'd0:    n = a[15:12];
      2'd1:    n = a[11:8];
      2'd2:    n = a[7:4];
      default: n = a[3:0];
    endcase
    return n;
  endfunction

  wssh_nib_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (load_cnt_q[IDX_W-1:0]),
    .wdata_i (item_i.nibble),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  assign step_inc  = step_q + LEN_W'(1);
  assign len_plus  = {1'b0, len_q} + (LEN_W+1)'(1);
  assign nbyte     = len_plus[LEN_W:1];
  assign start_nib = item_i.address[15:12];
  assign next_nib  = addr_nib(addr_q, step_inc[1:0]);

  always_comb begin
    unique case (mode_q)
      MODE_SET:   begin wr_code = cfg_i.set_code;   wr_k = ACK_K_SET;   end
      MODE_UNSET: begin wr_code = cfg_i.unset_code; wr_k = ACK_K_UNSET; end
      default:    begin wr_code = cfg_i.wr_code;    wr_k = ACK_K_NIB;   end
    endcase
  end

  // Keep the buffer output one nibble ahead of the write data phase.
  assign prefetch = step_d + LEN_W'(1);
  always_comb begin
    buf_raddr = '0;
    if (phase_d == PH_WR_DATA && ({1'b0, prefetch} < (LEN_W+1)'(MAX_NIBBLES))) begin
      buf_raddr = prefetch[IDX_W-1:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    addr_d      = addr_q;
    step_d      = step_q;
    len_d       = len_q;
    mode_d      = mode_q;
    exp_ack_d   = exp_ack_q;
    sum_d       = sum_q;
    seen_d      = seen_q;
    load_cnt_d  = load_cnt_q;
    buf_we      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      unique case (item_i.op)
        OP_LOAD: begin
          if (phase_q == PH_IDLE && load_cnt_q < CNT_W'(MAX_NIBBLES)) begin
            buf_we     = 1'b1;
            load_cnt_d = load_cnt_q + CNT_W'(1);
          end
        end
        OP_RESET: begin
          if (phase_q == PH_IDLE) begin
            phase_d        = PH_RESET;
            seen_d         = 1'b0;
            res_valid_o    = 1'b1;
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = RESET_TX;
          end
        end
        OP_READ: begin
          if (phase_q == PH_IDLE) begin
            res_valid_o = 1'b1;
            if (item_i.count == '0 ||
                {1'b0, item_i.count} > (LEN_W+1)'(MAX_NIBBLES)) begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_BAD_ARG;
            end else begin
              addr_d         = item_i.address;
              len_d          = item_i.count;
              step_d         = '0;
              phase_d        = PH_ADDR_RD;
              exp_ack_d      = {4'h0, start_nib};
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = {2'b00, start_nib, 2'b00} + ADDR_TX_BASE;
            end
          end
        end
        OP_WRITE: begin
          if (phase_q == PH_IDLE) begin
            load_cnt_d  = '0;
            res_valid_o = 1'b1;
            if (item_i.mode > MODE_NIB ||
                (item_i.mode == MODE_NIB &&
                 {1'b0, item_i.count} > (LEN_W+1)'(MAX_NIBBLES)) ||
                (item_i.mode != MODE_NIB && item_i.count > LEN_W'(1))) begin
              res_o.done_res = 1'b1;
              res_o.status   = ST_BAD_ARG;
            end else begin
              addr_d         = item_i.address;
              len_d          = item_i.count;
              mode_d         = item_i.mode;
              step_d         = '0;
              phase_d        = PH_ADDR_WR;
              exp_ack_d      = {4'h0, start_nib};
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = {2'b00, start_nib, 2'b00} + ADDR_TX_BASE;
            end
          end
        end
        OP_RX: begin
          unique case (phase_q)
            PH_RESET: begin
              if (item_i.rx_byte == RESET_REPLY) seen_d = 1'b1;
            end
            PH_ADDR_RD, PH_ADDR_WR: begin
              res_valid_o = 1'b1;
              if (item_i.rx_byte != exp_ack_q) begin
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
                res_o.status   = ST_BAD_ACK;
              end else if (step_inc < LEN_W'(4)) begin
                step_d         = step_inc;
                exp_ack_d      = {2'b00, step_inc[1:0], next_nib};
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = {2'b00, next_nib, 2'b00} + ADDR_TX_BASE;
              end else if (phase_q == PH_ADDR_RD) begin
                step_d         = '0;
                phase_d        = PH_RD_CMD;
                exp_ack_d      = RD_ACK_BASE + 8'(nbyte);
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = RD_TX_BASE + {nbyte[5:0], 2'b00};
              end else if (len_q == '0) begin
                step_d         = '0;
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
                res_o.status   = ST_OK;
              end else begin
                step_d         = '0;
                phase_d        = PH_WR_DATA;
                exp_ack_d      = {4'h0, buf_rdata} + wr_k;
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = wr_code + {2'b00, buf_rdata, 2'b00};
              end
            end
            PH_RD_CMD: begin
              if (item_i.rx_byte != exp_ack_q) begin
                phase_d        = PH_IDLE;
                res_valid_o    = 1'b1;
                res_o.done_res = 1'b1;
                res_o.status   = ST_BAD_ACK;
              end else begin
                phase_d = PH_RD_DATA;
                step_d  = '0;
                sum_d   = '0;
              end
            end
            PH_RD_DATA: begin
              sum_d            = sum_q + item_i.rx_byte;
              step_d           = step_inc;
              if (step_inc >= nbyte) phase_d = PH_RD_SUM;
              res_valid_o      = 1'b1;
              res_o.data_valid = 1'b1;
              res_o.data_byte  = item_i.rx_byte;
            end
            PH_RD_SUM: begin
              phase_d        = PH_IDLE;
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              res_o.status   = (item_i.rx_byte == sum_q) ? ST_OK : ST_BAD_SUM;
            end
            PH_WR_DATA: begin
              res_valid_o = 1'b1;
              if (item_i.rx_byte != exp_ack_q) begin
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
                res_o.status   = ST_BAD_ACK;
              end else if (step_inc >= len_q) begin
                step_d         = step_inc;
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
                res_o.status   = ST_OK;
              end else begin
                step_d         = step_inc;
                exp_ack_d      = {4'h0, buf_rdata} + wr_k;
                res_o.tx_valid = 1'b1;
                res_o.tx_byte  = wr_code + {2'b00, buf_rdata, 2'b00};
              end
            end
            default: ;
          endcase
        end
        OP_TIMEOUT: begin
          if (phase_q != PH_IDLE) begin
            phase_d        = PH_IDLE;
            res_valid_o    = 1'b1;
            res_o.done_res = 1'b1;
            if (phase_q == PH_RESET) begin
              res_o.status = seen_q ? ST_OK : ST_NO_REPLY;
            end else begin
              res_o.status = ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      addr_q     <= '0;
      step_q     <= '0;
      len_q      <= '0;
      mode_q     <= '0;
      exp_ack_q  <= '0;
      sum_q      <= '0;
      seen_q     <= 1'b0;
      load_cnt_q <= '0;
    end else begin
      phase_q    <= phase_d;
      addr_q     <= addr_d;
      step_q     <= step_d;
      len_q      <= len_d;
      mode_q     <= mode_d;
      exp_ack_q  <= exp_ack_d;
      sum_q      <= sum_d;
      seen_q     <= seen_d;
      load_cnt_q <= load_cnt_d;
    end
  end

endmodule

// ===== src/weather_station_serial_host_top.sv =====
// Top level of the weather station serial host: input stage, output stage, config registers.
// Depends on wssh_pkg and wssh_engine.
//
// Usage: feed event beats (load nibble, start reset/read/write, received byte,
// timeout) on the in channel; each beat yields zero or one result beat on the
// out channel (a byte to transmit, a read data byte, or a done status).
// Both channels are valid/stall: a beat moves when valid is high and stall low.
// Path: an accepted beat is registered in the input stage, stepped through
// the engine and its result is registered in the output register.
// Throughput: one beat per cycle while the receiver does not stall; the
// step rule is combinational and the nibble buffer read is prefetched one
// beat ahead.
// Receiver stall: the result holds in the output register; the input stage
// holds its beat and raises in_stall_o once it is full.
// Config: write the three write-mode encode codes through cfg_we_i/cfg_idx_i
// while idle; indexes beyond the list are dropped.
// Reset: clears phase, counters and both stages; codes return to defaults.
// The nibble buffer contents are not cleared.
module weather_station_serial_host_top import wssh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  wssh_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output wssh_out_t out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  logic      s1_valid_q, s1_valid_d;
  wssh_in_t  s1_q;
  logic      s1_adv;
  logic      fire;
  logic      in_accept;
  logic      out_valid_q, out_valid_d;
  wssh_out_t out_q;
  wssh_cfg_t cfg_q;
  logic      res_valid;
  wssh_out_t res;

  // Advance the input beat whenever the output register is free or draining.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_q <= in_data_i;
  end

  wssh_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (s1_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load the result on a step; otherwise drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) out_valid_d = res_valid;
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_code   <= SET_CODE_RST;
      cfg_q.unset_code <= UNSET_CODE_RST;
      cfg_q.wr_code    <= WR_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_CODE:   cfg_q.set_code   <= cfg_wdata_i;
        CFG_UNSET_CODE: cfg_q.unset_code <= cfg_wdata_i;
        CFG_WR_CODE:    cfg_q.wr_code    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result carries exactly one kind of payload.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.tx_valid, out_data_o.data_valid,
                                out_data_o.done_res}) == 1)
    else $error("result beat carries not exactly one kind");

  // Status is zero unless the beat reports a finished transaction.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.done_res) |-> out_data_o.status == ST_OK)
    else $error("status set on a non-done beat");

  // A blocked input beat stays in place.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("input stage lost a blocked beat");

  // A step never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("step fired into a stalled output register");

endmodule
